// ===== rtl/point_cloud_crop_transform_unit_macros.svh =====
// ----------------------------------------------------------------------------
// point cloud crop transform unit assertion macros
// concurrent assertion helpers clocked on aclk, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef POINT_CLOUD_CROP_TRANSFORM_UNIT_MACROS_SVH
`define POINT_CLOUD_CROP_TRANSFORM_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PCCT_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pcct assertion failed");

`define PCCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pcct assertion failed");

`else

`define PCCT_ASSERT_IMPLY(label, ante, cons)

`define PCCT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/pcct_pkg.sv =====
// ----------------------------------------------------------------------------
// pcct_pkg
// shared types and constants of the point cloud crop transform unit
// ----------------------------------------------------------------------------
package pcct_pkg;

    localparam int COEF_FRAC_BITS = 14;

    localparam int COORD_W = 17;
    localparam int TEX_W   = 18;
    localparam int OUT_W   = 18;
    localparam int SIZE_W  = 12;
    localparam int PIX_W   = 24;
    localparam int COEF_W  = 16;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 80;

    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;

    localparam logic [47:0]       CROP_RESET   = 48'hFFFF_FFFF_FFFF;
    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 12'd1280;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 12'd720;

    typedef enum logic [2:0] {
        REG_ROW_ZERO         = 3'd0,
        REG_ROW_ONE          = 3'd1,
        REG_ROW_TWO          = 3'd2,
        REG_CROP_LIMITS      = 3'd3,
        REG_TRANSFORM_ENABLE = 3'd4,
        REG_COLOR_ENABLE     = 3'd5,
        REG_TEX_WIDTH        = 3'd6,
        REG_TEX_HEIGHT       = 3'd7
    } reg_idx_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [TEX_W-1:0]   tex_t;
    typedef logic signed [OUT_W-1:0]   out_coord_t;
    typedef logic [SIZE_W-1:0]         size_t;

endpackage

// ===== rtl/point_cloud_crop_transform_unit.sv =====
// path: an accepted input transfer passes the input, product, accumulate and output registers to m_tdata
// throughput: one vertex per cycle, set by the four register stages that each
// take a new vertex whenever the stage after them moves or is empty
// dropped vertices leave the pipeline at stage two and produce no transfer
// reset: synchronous active low aresetn clears all stage valid bits and loads
// the register reset values (crop limits all ones, texture size 1280 by 720)
// ----------------------------------------------------------------------------
// point_cloud_crop_transform_unit
// crop box filter, fixed point rigid transform and texture pixel index
// ----------------------------------------------------------------------------
`include "point_cloud_crop_transform_unit_macros.svh"

module point_cloud_crop_transform_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // apb configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pcct_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pcct_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pcct_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // x_mm, y_mm, z_mm, tex_u, tex_v, zero pad
    input  logic [pcct_pkg::S_TDATA_W-1:0]  s_tdata,
    // point_valid
    input  logic                            s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_x, out_y, out_z, pixel_index, zero pad
    output logic [pcct_pkg::M_TDATA_W-1:0]  m_tdata,
    // has_color
    output logic                            m_tuser
);
    import pcct_pkg::*;

    localparam int PROD_W  = COEF_W + COORD_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int SHR_W   = ACC_W - COEF_FRAC_BITS;
    localparam int BASE_W  = (SHR_W > COORD_W) ? SHR_W : COORD_W;
    localparam int SUM_W   = BASE_W + 1;
    localparam int TPROD_W = TEX_W + SIZE_W + 1;
    localparam int TSUM_W  = TPROD_W + 1;
    localparam int IDX_W   = TSUM_W - 16;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [63:0]       row_reg [3];
    logic [47:0]       crop_limits_reg;
    logic              transform_enable_reg;
    logic              color_enable_reg;
    size_t             tex_width_reg;
    size_t             tex_height_reg;
    logic              cfg_write;
    reg_idx_t          cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0]           <= '0;
            row_reg[1]           <= '0;
            row_reg[2]           <= '0;
            crop_limits_reg      <= CROP_RESET;
            transform_enable_reg <= 1'b0;
            color_enable_reg     <= 1'b0;
            tex_width_reg        <= WIDTH_RESET;
            tex_height_reg       <= HEIGHT_RESET;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_ROW_ZERO:         row_reg[0]           <= pwdata;
                REG_ROW_ONE:          row_reg[1]           <= pwdata;
                REG_ROW_TWO:          row_reg[2]           <= pwdata;
                REG_CROP_LIMITS:      crop_limits_reg      <= pwdata[47:0];
                REG_TRANSFORM_ENABLE: transform_enable_reg <= pwdata[0];
                REG_COLOR_ENABLE:     color_enable_reg     <= pwdata[0];
                REG_TEX_WIDTH:        tex_width_reg        <= pwdata[SIZE_W-1:0];
                REG_TEX_HEIGHT:       tex_height_reg       <= pwdata[SIZE_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ROW_ZERO:         prdata = row_reg[0];
            REG_ROW_ONE:          prdata = row_reg[1];
            REG_ROW_TWO:          prdata = row_reg[2];
            REG_CROP_LIMITS:      prdata = {16'd0, crop_limits_reg};
            REG_TRANSFORM_ENABLE: prdata = {63'd0, transform_enable_reg};
            REG_COLOR_ENABLE:     prdata = {63'd0, color_enable_reg};
            REG_TEX_WIDTH:        prdata = {52'd0, tex_width_reg};
            REG_TEX_HEIGHT:       prdata = {52'd0, tex_height_reg};
        endcase
    end

    size_t width_eff;
    size_t height_eff;
    assign width_eff  = (tex_width_reg == '0)  ? SIZE_W'(1) : tex_width_reg;
    assign height_eff = (tex_height_reg == '0) ? SIZE_W'(1) : tex_height_reg;

    // ------------------------------------------------------------------------
    // stage flow control
    // ------------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4      = !v4_reg || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    // ------------------------------------------------------------------------
    // stage 1: input register
    // ------------------------------------------------------------------------
    coord_t x1_reg, y1_reg, z1_reg;
    tex_t   u1_reg, t1_reg;
    logic   pv1_reg;
    logic   v1_next;

    assign v1_next = en1 ? s_tvalid : v1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            x1_reg  <= s_tdata[16:0];
            y1_reg  <= s_tdata[33:17];
            z1_reg  <= s_tdata[50:34];
            u1_reg  <= s_tdata[68:51];
            t1_reg  <= s_tdata[86:69];
            pv1_reg <= s_tuser;
        end
    end

    // ------------------------------------------------------------------------
    // stage 2: crop test and products
    // ------------------------------------------------------------------------
    logic [COORD_W-1:0] ax1, ay1;
    logic               keep1;
    coord_t             xin1 [3];
    logic signed [PROD_W-1:0]  prod1 [3][3];
    logic signed [TPROD_W-1:0] tu_prod1, tv_prod1;

    assign ax1 = x1_reg[COORD_W-1] ? COORD_W'(-x1_reg) : COORD_W'(x1_reg);
    assign ay1 = y1_reg[COORD_W-1] ? COORD_W'(-y1_reg) : COORD_W'(y1_reg);

    assign keep1 = pv1_reg
                && (ax1 <= {1'b0, crop_limits_reg[15:0]})
                && (ay1 <= {1'b0, crop_limits_reg[31:16]})
                && !z1_reg[COORD_W-1] && (z1_reg != '0)
                && (z1_reg[COORD_W-2:0] <= crop_limits_reg[47:32]);

    assign xin1[0] = x1_reg;
    assign xin1[1] = y1_reg;
    assign xin1[2] = z1_reg;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod1[r][c] = PROD_W'($signed(row_reg[r][16*c +: COEF_W]))
                            * PROD_W'(xin1[c]);
            end
        end
    end

    assign tu_prod1 = TPROD_W'(u1_reg) * $signed(TPROD_W'({1'b0, width_eff}));
    assign tv_prod1 = TPROD_W'(t1_reg) * $signed(TPROD_W'({1'b0, height_eff}));

    logic signed [PROD_W-1:0]  prod2_reg [3][3];
    logic signed [TPROD_W-1:0] tu2_reg, tv2_reg;
    coord_t                    x2_reg, y2_reg, z2_reg;
    logic                      v2_next;

    assign v2_next = en2 ? (v1_reg && keep1) : v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else begin
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            prod2_reg <= prod1;
            tu2_reg   <= tu_prod1;
            tv2_reg   <= tv_prod1;
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            z2_reg    <= z1_reg;
        end
    end

    // ------------------------------------------------------------------------
    // stage 3: accumulate, round and offset or pass through, texture coordinate clamp
    // ------------------------------------------------------------------------
    logic signed [ACC_W-1:0] acc2 [3];
    logic signed [SHR_W-1:0] shr2 [3];
    logic signed [SUM_W-1:0] val2 [3];
    coord_t                  pass2 [3];

    assign pass2[0] = x2_reg;
    assign pass2[1] = y2_reg;
    assign pass2[2] = z2_reg;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            acc2[r] = ACC_W'(prod2_reg[r][0]) + ACC_W'(prod2_reg[r][1])
                    + ACC_W'(prod2_reg[r][2])
                    + ACC_W'(1 << (COEF_FRAC_BITS - 1));
            shr2[r] = SHR_W'(acc2[r] >>> COEF_FRAC_BITS);
            if (transform_enable_reg) begin
                val2[r] = SUM_W'(shr2[r])
                        + SUM_W'($signed(row_reg[r][63:48]));
            end else begin
                val2[r] = SUM_W'(pass2[r]);
            end
        end
    end

    function automatic size_t tex_clamp(input logic signed [TPROD_W-1:0] p,
                                        input size_t size);
        logic signed [TSUM_W-1:0] s;
        logic [IDX_W-1:0]         idx;
        size_t                    top;
        s   = TSUM_W'(p) + TSUM_W'(32768);
        idx = s[TSUM_W-1] ? '0 : s[TSUM_W-1:16];
        top = size - SIZE_W'(1);
        return (idx > IDX_W'(top)) ? top : idx[SIZE_W-1:0];
    endfunction

    logic signed [SUM_W-1:0] val3_reg [3];
    size_t                   col3_reg, row3_reg;
    logic                    v3_next;

    assign v3_next = en3 ? v2_reg : v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else begin
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            val3_reg <= val2;
            col3_reg <= tex_clamp(tu2_reg, width_eff);
            row3_reg <= tex_clamp(tv2_reg, height_eff);
        end
    end

    // ------------------------------------------------------------------------
    // stage 4: saturate, negate and pixel index, output register
    // ------------------------------------------------------------------------
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-(1 << (OUT_W - 1)));

    function automatic out_coord_t sat_out(input logic signed [SUM_W-1:0] v);
        if (v > SUM_MAX) begin
            return SUM_MAX[OUT_W-1:0];
        end else if (v < SUM_MIN) begin
            return SUM_MIN[OUT_W-1:0];
        end
        return v[OUT_W-1:0];
    endfunction

    function automatic out_coord_t neg_sat(input out_coord_t v);
        logic signed [OUT_W:0] n;
        n = -(OUT_W + 1)'(v);
        return (n > $signed((OUT_W + 1)'(SUM_MAX[OUT_W-1:0]))) ?
               SUM_MAX[OUT_W-1:0] : n[OUT_W-1:0];
    endfunction

    out_coord_t      ox3, oy3, oz3;
    logic [PIX_W-1:0] pix3;

    assign ox3  = neg_sat(sat_out(val3_reg[0]));
    assign oy3  = neg_sat(sat_out(val3_reg[1]));
    assign oz3  = sat_out(val3_reg[2]);
    assign pix3 = PIX_W'(row3_reg * width_eff) + PIX_W'(col3_reg);

    out_coord_t       ox4_reg, oy4_reg, oz4_reg;
    logic [PIX_W-1:0] pix4_reg;
    logic             hc4_reg;
    logic             v4_next;

    assign v4_next = en4 ? v3_reg : v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else begin
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            ox4_reg  <= ox3;
            oy4_reg  <= oy3;
            oz4_reg  <= oz3;
            hc4_reg  <= color_enable_reg;
            pix4_reg <= color_enable_reg ? pix3 : '0;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tuser  = hc4_reg;
    assign m_tdata  = {2'b00, pix4_reg, oz4_reg, oy4_reg, ox4_reg};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `PCCT_ASSERT_IMPLY(a_no_color_zero_index, m_tvalid && !m_tuser, m_tdata[77:54] == '0)
    `PCCT_ASSERT_IMPLY(a_neg_x_range, m_tvalid, m_tdata[17:0] != 18'h20000)
    `PCCT_ASSERT_IMPLY(a_neg_y_range, m_tvalid, m_tdata[35:18] != 18'h20000)
    `PCCT_ASSERT_NEXT(a_stall_holds_pipe, v3_reg && v4_reg && !m_tready, v3_reg && v4_reg)

endmodule
